@@ src/f2dc_pkg.sv @@
// Shared definitions for the full 2D convolution block: command codes,
// register indexes, parameter defaults and the control structs between modules.
// No dependencies.
`timescale 1ns / 1ps

package f2dc_pkg;

	localparam int DEF_MAX_IMAGE_ROWS = 32;
	localparam int DEF_MAX_IMAGE_COLS = 32;
	localparam int DEF_MAX_KERNEL_DIM = 8;

	// Stages between a tap read and its product landing in the accumulator.
	localparam int PIPE_DEPTH = 2;

	localparam logic [1:0] CMD_WR_IMAGE  = 2'd0;
	localparam logic [1:0] CMD_WR_KERNEL = 2'd1;
	localparam logic [1:0] CMD_QUERY     = 2'd2;

	localparam logic [7:0] REG_IMAGE_ROWS  = 8'd0;
	localparam logic [7:0] REG_IMAGE_COLS  = 8'd1;
	localparam logic [7:0] REG_KERNEL_ROWS = 8'd2;
	localparam logic [7:0] REG_KERNEL_COLS = 8'd3;

	// One kernel tap on its way through the read and multiply stages.
	typedef struct packed {
		logic issue;
		logic tap_ok;
	} f2dc_tap_t;

	// Element write strobes for the two stores.
	typedef struct packed {
		logic img_we;
		logic ker_we;
	} f2dc_wr_t;

	// Sequencer status toward the top level.
	typedef struct packed {
		logic idle;
		logic finish;
		logic in_range;
	} f2dc_stat_t;

endpackage

@@ src/f2dc_store.sv @@
// Image and kernel element memories with one write and one registered read port each.
// Depends on f2dc_pkg.
`timescale 1ns / 1ps

module f2dc_store
	import f2dc_pkg::*;
#(
	parameter int MAX_IMAGE_ROWS = DEF_MAX_IMAGE_ROWS,
	parameter int MAX_IMAGE_COLS = DEF_MAX_IMAGE_COLS,
	parameter int MAX_KERNEL_DIM = DEF_MAX_KERNEL_DIM,
	localparam int IMG_DEPTH = MAX_IMAGE_ROWS * MAX_IMAGE_COLS,
	localparam int KER_DEPTH = MAX_KERNEL_DIM * MAX_KERNEL_DIM,
	localparam int IAW = (IMG_DEPTH > 1) ? $clog2(IMG_DEPTH) : 1,
	localparam int KAW = (KER_DEPTH > 1) ? $clog2(KER_DEPTH) : 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  f2dc_wr_t           wr,
	input  logic [5:0]         wr_row,
	input  logic [5:0]         wr_col,
	input  logic signed [15:0] wr_value,
	input  f2dc_tap_t          tap,
	input  logic [IAW-1:0]     img_raddr,
	input  logic [KAW-1:0]     ker_raddr,
	output f2dc_tap_t          tap_s1,
	output logic signed [15:0] img_data_s1,
	output logic signed [15:0] ker_data_s1
);

	logic signed [15:0] img_mem [IMG_DEPTH];
	logic signed [15:0] ker_mem [KER_DEPTH];

	logic           img_fit;
	logic           ker_fit;
	logic [IAW-1:0] img_waddr;
	logic [KAW-1:0] ker_waddr;

	// Writes outside the storage are dropped.
	assign img_fit = (int'(wr_row) < MAX_IMAGE_ROWS) && (int'(wr_col) < MAX_IMAGE_COLS);
	assign ker_fit = (int'(wr_row) < MAX_KERNEL_DIM) && (int'(wr_col) < MAX_KERNEL_DIM);
	assign img_waddr = img_fit ? IAW'(int'(wr_row) * MAX_IMAGE_COLS + int'(wr_col)) : '0;
	assign ker_waddr = ker_fit ? KAW'(int'(wr_row) * MAX_KERNEL_DIM + int'(wr_col)) : '0;

	always_ff @(posedge clk) begin
		if (wr.img_we && img_fit) begin
			img_mem[img_waddr] <= wr_value;
		end
		img_data_s1 <= img_mem[img_raddr];
	end

	always_ff @(posedge clk) begin
		if (wr.ker_we && ker_fit) begin
			ker_mem[ker_waddr] <= wr_value;
		end
		ker_data_s1 <= ker_mem[ker_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_s1 <= '0;
		end else begin
			tap_s1 <= tap;
		end
	end

endmodule

@@ src/f2dc_mac.sv @@
// Shared multiply-accumulate unit: one registered 16x16 product, then a 40-bit accumulate.
// Depends on f2dc_pkg.
`timescale 1ns / 1ps

module f2dc_mac
	import f2dc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               clear,
	input  f2dc_tap_t          tap_s1,
	input  logic signed [15:0] img_data_s1,
	input  logic signed [15:0] ker_data_s1,
	output logic signed [39:0] acc_q
);

	logic signed [31:0] prod_s2;
	logic               live_s2;

	always_ff @(posedge clk) begin
		prod_s2 <= tap_s1.tap_ok ? img_data_s1 * ker_data_s1 : 32'sd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_s2 <= 1'b0;
			acc_q   <= '0;
		end else begin
			live_s2 <= tap_s1.issue;
			if (clear) begin
				acc_q <= '0;
			end else if (live_s2) begin
				acc_q <= acc_q + {{8{prod_s2[31]}}, prod_s2};
			end
		end
	end

endmodule

@@ src/f2dc_seq.sv @@
// Query sequencer: walks the kernel taps, forms the memory read addresses and
// waits for the multiply-accumulate pipeline to drain. Depends on f2dc_pkg.
`timescale 1ns / 1ps

module f2dc_seq
	import f2dc_pkg::*;
#(
	parameter int MAX_IMAGE_ROWS = DEF_MAX_IMAGE_ROWS,
	parameter int MAX_IMAGE_COLS = DEF_MAX_IMAGE_COLS,
	parameter int MAX_KERNEL_DIM = DEF_MAX_KERNEL_DIM,
	localparam int IMG_DEPTH = MAX_IMAGE_ROWS * MAX_IMAGE_COLS,
	localparam int KER_DEPTH = MAX_KERNEL_DIM * MAX_KERNEL_DIM,
	localparam int IAW = (IMG_DEPTH > 1) ? $clog2(IMG_DEPTH) : 1,
	localparam int KAW = (KER_DEPTH > 1) ? $clog2(KER_DEPTH) : 1
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [5:0]     row,
	input  logic [5:0]     col,
	input  logic [5:0]     image_rows,
	input  logic [5:0]     image_cols,
	input  logic [3:0]     kernel_rows,
	input  logic [3:0]     kernel_cols,
	input  logic           out_busy,
	output f2dc_tap_t      tap,
	output logic [IAW-1:0] img_raddr,
	output logic [KAW-1:0] ker_raddr,
	output f2dc_stat_t     stat
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_RUN   = 4'b0010,
		ST_FLUSH = 4'b0100,
		ST_DONE  = 4'b1000
	} f2dc_state_t;

	f2dc_state_t state_q;
	logic [5:0]  row_q;
	logic [5:0]  col_q;
	logic [3:0]  kr_q;
	logic [3:0]  kc_q;
	logic [1:0]  flush_q;
	logic        in_range_q;

	logic       start_in_range;
	logic       last_tap;
	logic       row_ok;
	logic       col_ok;
	logic [5:0] img_r;
	logic [5:0] img_c;

	assign start_in_range =
		(7'(row) < 7'(image_rows) + 7'(kernel_rows) - 7'd1) &&
		(7'(col) < 7'(image_cols) + 7'(kernel_cols) - 7'd1);

	assign last_tap = (kc_q == kernel_cols - 4'd1) && (kr_q == kernel_rows - 4'd1);

	// A tap counts only where the shifted position falls inside the image.
	assign img_r  = row_q - 6'(kr_q);
	assign img_c  = col_q - 6'(kc_q);
	assign row_ok = (6'(kr_q) <= row_q) && (img_r < image_rows);
	assign col_ok = (6'(kc_q) <= col_q) && (img_c < image_cols);

	assign tap.issue  = (state_q == ST_RUN);
	assign tap.tap_ok = (state_q == ST_RUN) && row_ok && col_ok;
	assign img_raddr  = tap.tap_ok ? IAW'(int'(img_r) * MAX_IMAGE_COLS + int'(img_c)) : '0;
	assign ker_raddr  = tap.tap_ok ? KAW'(int'(kr_q) * MAX_KERNEL_DIM + int'(kc_q)) : '0;

	assign stat.idle     = (state_q == ST_IDLE);
	assign stat.finish   = (state_q == ST_DONE) && !out_busy;
	assign stat.in_range = in_range_q;

	always_ff @(posedge clk) begin
		if (start) begin
			row_q <= row;
			col_q <= col;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			kr_q       <= '0;
			kc_q       <= '0;
			flush_q    <= '0;
			in_range_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						kr_q       <= '0;
						kc_q       <= '0;
						in_range_q <= start_in_range;
						state_q    <= start_in_range ? ST_RUN : ST_DONE;
					end
				end
				ST_RUN: begin
					if (last_tap) begin
						flush_q <= '0;
						state_q <= ST_FLUSH;
					end else if (kc_q == kernel_cols - 4'd1) begin
						kc_q <= '0;
						kr_q <= kr_q + 4'd1;
					end else begin
						kc_q <= kc_q + 4'd1;
					end
				end
				ST_FLUSH: begin
					if (flush_q == 2'(PIPE_DEPTH - 1)) begin
						state_q <= ST_DONE;
					end else begin
						flush_q <= flush_q + 2'd1;
					end
				end
				ST_DONE: begin
					if (!out_busy) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

@@ src/full_2d_convolution.sv @@
// Full 2D convolution: a write request completes when accepted and gives no result.
// A query in range walks the kernel taps in the run state, one kernel tap per cycle
// through the one shared multiply-accumulate, drains the pipeline in the flush state
// and waits in the done state until the output register is free; no new request is
// taken meanwhile. A query outside the output size goes straight to the done state.
// Asynchronous active-low reset restores the size registers; element memories are undefined.
`timescale 1ns / 1ps

module full_2d_convolution
	import f2dc_pkg::*;
#(
	parameter int MAX_IMAGE_ROWS = DEF_MAX_IMAGE_ROWS,
	parameter int MAX_IMAGE_COLS = DEF_MAX_IMAGE_COLS,
	parameter int MAX_KERNEL_DIM = DEF_MAX_KERNEL_DIM
) (
	input  logic               clk,
	input  logic               arst_n,

	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         command,
	input  logic [5:0]         row,
	input  logic [5:0]         col,
	input  logic signed [15:0] value,

	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [39:0] sum,
	output logic               in_range,

	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [7:0]         cfg_index,
	input  logic [7:0]         cfg_data
);

	localparam int IMG_DEPTH = MAX_IMAGE_ROWS * MAX_IMAGE_COLS;
	localparam int KER_DEPTH = MAX_KERNEL_DIM * MAX_KERNEL_DIM;
	localparam int IAW = (IMG_DEPTH > 1) ? $clog2(IMG_DEPTH) : 1;
	localparam int KAW = (KER_DEPTH > 1) ? $clog2(KER_DEPTH) : 1;

	// Size registers are held saturated into one up to the storage maximum.
	function automatic int clamp_dim(int v, int maxv);
		int r;
		r = v;
		if (v < 1) begin
			r = 1;
		end else if (v > maxv) begin
			r = maxv;
		end
		return r;
	endfunction

	localparam logic [5:0] IMAGE_ROWS_RST  = 6'(clamp_dim(32, MAX_IMAGE_ROWS));
	localparam logic [5:0] IMAGE_COLS_RST  = 6'(clamp_dim(32, MAX_IMAGE_COLS));
	localparam logic [3:0] KERNEL_ROWS_RST = 4'(clamp_dim(3, MAX_KERNEL_DIM));
	localparam logic [3:0] KERNEL_COLS_RST = 4'(clamp_dim(3, MAX_KERNEL_DIM));

	logic [5:0] image_rows_q;
	logic [5:0] image_cols_q;
	logic [3:0] kernel_rows_q;
	logic [3:0] kernel_cols_q;

	logic               in_fire;
	logic               start;
	f2dc_wr_t           wr;
	f2dc_tap_t          tap;
	f2dc_tap_t          tap_s1;
	f2dc_stat_t         stat;
	logic [IAW-1:0]     img_raddr;
	logic [KAW-1:0]     ker_raddr;
	logic signed [15:0] img_data_s1;
	logic signed [15:0] ker_data_s1;
	logic signed [39:0] acc_q;

	logic               out_valid_q;
	logic signed [39:0] sum_q;
	logic               in_range_q;

	// Users must change configuration only while idle (unchecked); port never stalls.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_rows_q  <= IMAGE_ROWS_RST;
			image_cols_q  <= IMAGE_COLS_RST;
			kernel_rows_q <= KERNEL_ROWS_RST;
			kernel_cols_q <= KERNEL_COLS_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_IMAGE_ROWS: begin
					image_rows_q <= 6'(clamp_dim(int'(cfg_data[5:0]), MAX_IMAGE_ROWS));
				end
				REG_IMAGE_COLS: begin
					image_cols_q <= 6'(clamp_dim(int'(cfg_data[5:0]), MAX_IMAGE_COLS));
				end
				REG_KERNEL_ROWS: begin
					kernel_rows_q <= 4'(clamp_dim(int'(cfg_data[3:0]), MAX_KERNEL_DIM));
				end
				REG_KERNEL_COLS: begin
					kernel_cols_q <= 4'(clamp_dim(int'(cfg_data[3:0]), MAX_KERNEL_DIM));
				end
				default: begin
					// Indexes past the register list are dropped.
				end
			endcase
		end
	end

	// Requests are taken only while the sequencer is idle. Element writes land in
	// the memories at the accepting edge; the unused command code is accepted and dropped.
	assign in_ready   = stat.idle;
	assign in_fire    = in_valid && in_ready;
	assign start      = in_fire && (command == CMD_QUERY);
	assign wr.img_we  = in_fire && (command == CMD_WR_IMAGE);
	assign wr.ker_we  = in_fire && (command == CMD_WR_KERNEL);

	f2dc_seq #(
		.MAX_IMAGE_ROWS(MAX_IMAGE_ROWS),
		.MAX_IMAGE_COLS(MAX_IMAGE_COLS),
		.MAX_KERNEL_DIM(MAX_KERNEL_DIM)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.row         (row),
		.col         (col),
		.image_rows  (image_rows_q),
		.image_cols  (image_cols_q),
		.kernel_rows (kernel_rows_q),
		.kernel_cols (kernel_cols_q),
		.out_busy    (out_valid_q && !out_ready),
		.tap         (tap),
		.img_raddr   (img_raddr),
		.ker_raddr   (ker_raddr),
		.stat        (stat)
	);

	f2dc_store #(
		.MAX_IMAGE_ROWS(MAX_IMAGE_ROWS),
		.MAX_IMAGE_COLS(MAX_IMAGE_COLS),
		.MAX_KERNEL_DIM(MAX_KERNEL_DIM)
	) u_store (
		.clk         (clk),
		.arst_n      (arst_n),
		.wr          (wr),
		.wr_row      (row),
		.wr_col      (col),
		.wr_value    (value),
		.tap         (tap),
		.img_raddr   (img_raddr),
		.ker_raddr   (ker_raddr),
		.tap_s1      (tap_s1),
		.img_data_s1 (img_data_s1),
		.ker_data_s1 (ker_data_s1)
	);

	// The accumulator is cleared when a query is accepted, so a query outside
	// the output size, which issues no taps, reads back zero.
	f2dc_mac u_mac (
		.clk         (clk),
		.arst_n      (arst_n),
		.clear       (start),
		.tap_s1      (tap_s1),
		.img_data_s1 (img_data_s1),
		.ker_data_s1 (ker_data_s1),
		.acc_q       (acc_q)
	);

	// Output register: a finished result waits here until the consumer takes it.
	always_ff @(posedge clk) begin
		if (stat.finish) begin
			sum_q      <= stat.in_range ? acc_q : '0;
			in_range_q <= stat.in_range;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (stat.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign sum       = sum_q;
	assign in_range  = in_range_q;

`ifndef SYNTH
	// A result outside the output size always carries a zero sum.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !in_range |-> sum == '0)
	else $error("out-of-range result with nonzero sum");

	// A query holds off further requests while its taps are walked.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && command == CMD_QUERY |=> !in_ready)
	else $error("request accepted during a query");

	// Any other request completes in the cycle it is accepted.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && command != CMD_QUERY |=> in_ready)
	else $error("write request stalled the block");

	// A new result is only produced from an idle-to-busy query.
	assert property (@(posedge clk) disable iff (!arst_n)
		stat.finish |-> !in_ready)
	else $error("result finished while idle");
`endif

endmodule
